>>> rtl/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg: bounded positional list shared definitions
// beat types, op and status codes, sizes and the per-cell command
// ----------------------------------------------------------------------------
package bpl_pkg;

  localparam int Capacity = 64;
  localparam int ElemW    = 32;

  // fixed field widths
  localparam int OpW     = 3;
  localparam int PosW    = 7;
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int LengthW = 7;

  // derived sizes
  localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW = $clog2(Capacity + 1);
  localparam int CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef enum logic [OpW-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_REAR  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_REAR  = 3'd3,
    OP_DEL_AT    = 3'd4,
    OP_INS_AT    = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [PosW-1:0]   position;
    logic [ValueW-1:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic [ValueW-1:0]  value_out;
    logic [StatusW-1:0] status;
    logic [LengthW-1:0] length;
  } out_beat_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IdxW-1:0]  idx;
    logic [ElemW-1:0] val;
  } cell_cmd_t;

endpackage

>>> rtl/bpl_cell.sv
// ----------------------------------------------------------------------------
// bpl_cell: one list slot
// holds one element, loads the new value on an insert at its index, takes from its left or right neighbor on a shift
// ----------------------------------------------------------------------------
module bpl_cell (
  input  logic                               clk_i,
  input  bpl_pkg::cell_cmd_t                 cmd_i,
  input  logic [bpl_pkg::IdxW-1:0]           idx_i,
  input  logic [bpl_pkg::ElemW-1:0]          left_i,
  input  logic [bpl_pkg::ElemW-1:0]          right_i,
  output logic [bpl_pkg::ElemW-1:0]          data_o,
  output logic [bpl_pkg::ElemW-1:0]          hit_o
);

  logic [bpl_pkg::ElemW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    priority if (cmd_i.ins && (idx_i > cmd_i.idx)) begin
      data_d = left_i;
    end else if (cmd_i.ins && (idx_i == cmd_i.idx)) begin
      data_d = cmd_i.val;
    end else if (cmd_i.del && (idx_i >= cmd_i.idx)) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  // element storage, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // masked read, or-combined across the row
  assign hit_o  = (idx_i == cmd_i.idx) ? data_q : '0;

endmodule

>>> rtl/bpl_chain.sv
// ----------------------------------------------------------------------------
// bpl_chain: row of list cells
// links neighbors and gathers the element at the command index
// ----------------------------------------------------------------------------
module bpl_chain (
  input  logic                      clk_i,
  input  bpl_pkg::cell_cmd_t        cmd_i,
  output logic [bpl_pkg::ElemW-1:0] rd_data_o
);

  logic [bpl_pkg::ElemW-1:0] data [bpl_pkg::Capacity];
  logic [bpl_pkg::ElemW-1:0] hit  [bpl_pkg::Capacity];

  for (genvar i = 0; i < bpl_pkg::Capacity; i++) begin : g_cell
    logic [bpl_pkg::ElemW-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[i-1];
    end

    if (i == bpl_pkg::Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    bpl_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_i),
      .idx_i  (bpl_pkg::IdxW'(i)),
      .left_i (left),
      .right_i(right),
      .data_o (data[i]),
      .hit_o  (hit[i])
    );
  end

  always_comb begin
    rd_data_o = '0;
    for (int i = 0; i < bpl_pkg::Capacity; i++) begin
      rd_data_o = rd_data_o | hit[i];
    end
  end

endmodule

>>> rtl/bounded_positional_list.sv
// ----------------------------------------------------------------------------
// bounded_positional_list: ordered list with positional insert and delete
// front/rear add and remove, remove at position, insert before position
// ----------------------------------------------------------------------------
// a result beat is registered and shown in the cycle after the request beat is taken
// throughput: one request per cycle while the result side keeps up; every taken
//   insert or delete moves the cells at and after its index along the row
// reset: clears the element count and the result valid; the cells keep
//   whatever they held and are only read once written
module bounded_positional_list (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bpl_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bpl_pkg::out_beat_t  out_beat_o
);

  localparam int IdxW = bpl_pkg::IdxW;
  localparam int CntW = bpl_pkg::CntW;
  localparam int CmpW = bpl_pkg::CmpW;

  // element count and result register
  logic [CntW-1:0]    occ_d, occ_q;
  logic               out_valid_d, out_valid_q;
  bpl_pkg::out_beat_t out_beat_d, out_beat_q;

  logic               accept;
  logic               full, empty;
  logic [CmpW-1:0]    pos_w, occ_w, pos_m1;
  logic [CntW-1:0]    occ_m1;
  logic               do_ins, do_del;
  logic [IdxW-1:0]    idx;
  logic [CntW-1:0]    occ_next;
  bpl_pkg::status_e   status;
  bpl_pkg::cell_cmd_t cmd;
  logic [bpl_pkg::ElemW-1:0] rd_data;

  // a new request is taken unless a finished result is held up
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full   = (occ_q == CntW'(bpl_pkg::Capacity));
  assign empty  = (occ_q == '0);
  assign pos_w  = CmpW'(in_beat_i.position);
  assign occ_w  = CmpW'(occ_q);
  assign pos_m1 = pos_w - CmpW'(1);
  assign occ_m1 = occ_q - CntW'(1);

  // request decode: range check first, then empty / full
  always_comb begin
    status   = bpl_pkg::ST_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    idx      = '0;
    occ_next = occ_q;
    unique case (bpl_pkg::op_e'(in_beat_i.op))
      bpl_pkg::OP_ADD_FRONT, bpl_pkg::OP_ADD_REAR: begin
        if (full) begin
          status = bpl_pkg::ST_FULL;
        end else begin
          do_ins   = 1'b1;
          idx      = (bpl_pkg::op_e'(in_beat_i.op) == bpl_pkg::OP_ADD_FRONT) ?
                     '0 : occ_q[IdxW-1:0];
          occ_next = occ_q + CntW'(1);
        end
      end
      bpl_pkg::OP_DEL_FRONT, bpl_pkg::OP_DEL_REAR: begin
        if (empty) begin
          status = bpl_pkg::ST_UNDERFLOW;
        end else begin
          do_del   = 1'b1;
          idx      = (bpl_pkg::op_e'(in_beat_i.op) == bpl_pkg::OP_DEL_FRONT) ?
                     '0 : occ_m1[IdxW-1:0];
          occ_next = occ_m1;
        end
      end
      bpl_pkg::OP_DEL_AT: begin
        if ((pos_w == '0) || (pos_w > occ_w)) begin
          status = bpl_pkg::ST_RANGE;
        end else begin
          do_del   = 1'b1;
          idx      = pos_m1[IdxW-1:0];
          occ_next = occ_m1;
        end
      end
      bpl_pkg::OP_INS_AT: begin
        if ((pos_w == '0) || (pos_w > (occ_w + CmpW'(1)))) begin
          status = bpl_pkg::ST_RANGE;
        end else if (full) begin
          status = bpl_pkg::ST_FULL;
        end else begin
          do_ins   = 1'b1;
          idx      = pos_m1[IdxW-1:0];
          occ_next = occ_q + CntW'(1);
        end
      end
      default: begin
        // unused op codes leave the list alone
        status = bpl_pkg::ST_OK;
      end
    endcase
  end

  // command broadcast to the cell row, only on a taken beat
  assign cmd.ins = do_ins && accept;
  assign cmd.del = do_del && accept;
  assign cmd.idx = idx;
  assign cmd.val = in_beat_i.value_in[bpl_pkg::ElemW-1:0];

  bpl_chain u_chain (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .rd_data_o(rd_data)
  );

  always_comb begin
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    out_beat_d  = out_beat_q;
    if (accept) begin
      occ_d                = occ_next;
      out_valid_d          = 1'b1;
      out_beat_d.value_out = do_del ? bpl_pkg::ValueW'(rd_data) : '0;
      out_beat_d.status    = status;
      out_beat_d.length    = bpl_pkg::LengthW'(occ_next);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

>>> rtl/bpl_checker.sv
// ----------------------------------------------------------------------------
// bpl_checker: port-level checks for the bounded positional list
// result timing, held results and status versus reported length
// ----------------------------------------------------------------------------
module bpl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bpl_pkg::out_beat_t out_beat_o
);

  // a taken request shows its result on the next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("no result beat after a taken request");

  // a stalled result stays
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

  // underflow is only possible on an empty list
  a_underflow_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == bpl_pkg::ST_UNDERFLOW)
      |-> (out_beat_o.length == '0))
    else $error("underflow reported with elements present");

  // full is only possible at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == bpl_pkg::ST_FULL)
      |-> (out_beat_o.length == bpl_pkg::LengthW'(bpl_pkg::Capacity)))
    else $error("full reported below capacity");

endmodule

bind bounded_positional_list bpl_checker u_bpl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_beat_o (out_beat_o)
);
